// ----- design/contiguous_frame_allocator_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the contiguous frame allocator.
// ---------------------------------------------------------------------------
`ifndef CONTIGUOUS_FRAME_ALLOCATOR_MACROS_SVH
`define CONTIGUOUS_FRAME_ALLOCATOR_MACROS_SVH
`ifndef SYNTHESIS
`define CFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define CFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define CFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define CFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ----- design/cfa_pkg.sv -----
// ---------------------------------------------------------------------------
// cfa_pkg
// Shared constants for the contiguous frame allocator.
// ---------------------------------------------------------------------------
package cfa_pkg;
  localparam int CfaMaxFrames = 1024;
  localparam int FnW = 20;
  localparam int CntW = 11;
  localparam logic [1:0] ST_FREE  = 2'b11;
  localparam logic [1:0] ST_HEAD  = 2'b10;
  localparam logic [1:0] ST_ALLOC = 2'b00;
  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_REL   = 2'd1;
  localparam logic [1:0] MODE_MARK  = 2'd2;
  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NOSPACE = 2'd1;
  localparam logic [1:0] STAT_NOTHEAD = 2'd2;
  localparam logic [1:0] STAT_RANGE   = 2'd3;
  localparam logic CFG_BASE = 1'b0;
  localparam logic CFG_SIZE = 1'b1;
  // Memory port request from the sequencer.
  typedef struct packed {
    logic        wr;
    logic [1:0]  wdata;
  } cfa_mem_ctl_t;
endpackage

// ----- design/contiguous_frame_allocator.sv -----
// ---------------------------------------------------------------------------
// contiguous_frame_allocator
// First-fit allocator over a two-bit frame state store.
// ---------------------------------------------------------------------------
// Channel  Dir  Fields (tdata, lowest bit first)
// in_      in   mode[1:0], frame_number[21:2], frame_count[32:22]
// out_     out  first_frame[19:0], status[21:20], free_frames[32:22]
// cfg_     in   index 0 pool_base, index 1 pool_size
//
// After reset, and after any register write, a clearing pass writes every
// entry free, one a cycle, and no word is accepted meanwhile.
// Allocate reads one frame a cycle until the run is found, then writes the
// run one frame a cycle. Release walks the head and its allocated frames;
// mark reads then writes its range. A rejected request goes straight to
// the result. The result waits in the output register until taken while
// the next word is accepted; a later result waits for it.
module contiguous_frame_allocator
  import cfa_pkg::*;
#(
  parameter int MAX_FRAMES = CfaMaxFrames
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // mode, frame_number, frame_count
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // first_frame, status, free_frames
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_wdata
);
`include "contiguous_frame_allocator_macros.svh"
  localparam int AW = $clog2(MAX_FRAMES);
  localparam int LW = AW + 1;

  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_WR   = 3'd3;
  localparam logic [2:0] S_REL  = 3'd4;
  localparam logic [2:0] S_DONE = 3'd5;

  logic [2:0]       st_r, st_nxt;
  logic [FnW-1:0]   base_r;
  logic [CntW-1:0]  size_r;
  logic [CntW-1:0]  free_r, free_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [LW-1:0]    cnt_r, cnt_nxt;   // requested count (clipped)
  logic [LW-1:0]    k_r, k_nxt;       // address of read issued
  logic [LW-1:0]    run_r, run_nxt;
  logic [LW-1:0]    start_r, start_nxt;
  logic [LW-1:0]    wp_r, wp_nxt;     // write pointer
  logic [LW-1:0]    taken_r, taken_nxt;
  logic [FnW-1:0]   ff_r, ff_nxt;
  logic [1:0]       stat_r, stat_nxt;
  logic [FnW-1:0]   res_ff_r, res_ff_nxt;
  logic [1:0]       res_st_r, res_st_nxt;
  logic [CntW-1:0]  fout_r, fout_nxt;
  logic             ov_r, ov_nxt;
  logic [LW-1:0]    len;
  logic [LW-1:0]    raddr;
  logic [1:0]       rdata;
  logic [AW-1:0]    waddr;
  cfa_mem_ctl_t     mctl;
  logic [1:0]       in_mode;
  logic [FnW-1:0]   in_fn, in_off;
  logic [CntW-1:0]  in_cnt;
  logic             in_acc;
  logic             off_ok;
  logic [CntW:0]    sz_clip;

  assign in_mode = in_tdata[1:0];
  assign in_fn   = in_tdata[21:2];
  assign in_cnt  = in_tdata[32:22];
  assign in_off  = in_fn - base_r;

  // Pool length in use: size clipped to the store and rounded down to four.
  always_comb begin
    sz_clip = {1'b0, size_r};
    if (int'(sz_clip) > MAX_FRAMES) sz_clip = (CntW+1)'(MAX_FRAMES);
    sz_clip[1:0] = 2'b00;
    len = LW'(sz_clip);
  end

  assign off_ok = (in_fn >= base_r) && (in_off < FnW'(len));
  assign in_tready = (st_r == S_IDLE);
  assign in_acc = in_tvalid && in_tready;

  // Sequencer.
  always_comb begin
    st_nxt = st_r; free_nxt = free_r; mode_nxt = mode_r; cnt_nxt = cnt_r;
    k_nxt = k_r; run_nxt = run_r; start_nxt = start_r; wp_nxt = wp_r;
    taken_nxt = taken_r; ff_nxt = ff_r; stat_nxt = stat_r;
    res_ff_nxt = res_ff_r; res_st_nxt = res_st_r;
    fout_nxt = fout_r; ov_nxt = ov_r;
    raddr = k_r; waddr = wp_r[AW-1:0];
    mctl.wr = 1'b0; mctl.wdata = ST_FREE;
    if (ov_r && out_tready) ov_nxt = 1'b0;
    unique case (st_r)
      S_CLR: begin
        mctl.wr = 1'b1;
        wp_nxt = wp_r + 1'b1;
        if (wp_r == LW'(MAX_FRAMES - 1)) begin
          st_nxt = S_IDLE;
          free_nxt = CntW'(len);
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          mode_nxt = in_mode; k_nxt = '0; run_nxt = '0; taken_nxt = '0;
          ff_nxt = '0; stat_nxt = STAT_RANGE;
          cnt_nxt = (in_cnt > CntW'(len)) ? len + 1'b1 : LW'(in_cnt);
          priority if (in_mode == MODE_ALLOC && in_cnt != '0 && len != '0) begin
            st_nxt = S_SCAN; raddr = '0; k_nxt = LW'(1);
          end else if (in_mode == MODE_REL && off_ok) begin
            st_nxt = S_REL; raddr = LW'(in_off); k_nxt = LW'(in_off) + 1'b1;
            start_nxt = LW'(in_off);
          end else if (in_mode == MODE_MARK && in_cnt != '0 && off_ok &&
                       {1'b0, in_cnt} <= (CntW+1)'(len) - (CntW+1)'(in_off)) begin
            st_nxt = S_SCAN; raddr = LW'(in_off); k_nxt = LW'(in_off) + 1'b1;
            start_nxt = LW'(in_off);
          end else begin
            if (in_mode == MODE_ALLOC && in_cnt != '0) stat_nxt = STAT_NOSPACE;
            st_nxt = S_DONE;
          end
        end
      end
      S_SCAN: begin
        // One frame per cycle; rdata holds the frame at k_r - 1.
        raddr = k_r;
        if (mode_r == MODE_ALLOC) begin
          if (rdata == ST_FREE) begin
            run_nxt = run_r + 1'b1;
            if (run_r + 1'b1 == cnt_r) begin
              start_nxt = k_r - cnt_r; wp_nxt = k_r - cnt_r;
              st_nxt = S_WR;
            end
          end else run_nxt = '0;
          if (st_nxt == S_SCAN) begin
            if (k_r == len) begin
              stat_nxt = STAT_NOSPACE; st_nxt = S_DONE;
            end else begin
              k_nxt = k_r + 1'b1;
            end
          end
        end else begin
          if (rdata == ST_FREE) taken_nxt = taken_r + 1'b1;
          if (k_r - start_r == cnt_r) begin
            wp_nxt = start_r; st_nxt = S_WR;
          end else k_nxt = k_r + 1'b1;
        end
      end
      S_WR: begin
        mctl.wr = 1'b1;
        mctl.wdata = (wp_r == start_r) ? ST_HEAD : ST_ALLOC;
        wp_nxt = wp_r + 1'b1;
        if (wp_r + 1'b1 - start_r == cnt_r) begin
          stat_nxt = STAT_OK; st_nxt = S_DONE;
          if (mode_r == MODE_ALLOC) begin
            free_nxt = free_r - CntW'(cnt_r);
            ff_nxt = base_r + FnW'(start_r);
          end else free_nxt = free_r - CntW'(taken_r);
        end
      end
      S_REL: begin
        // Read of frame k_r - 1 is in rdata; free it while it belongs to the run.
        raddr = k_r;
        waddr = AW'(k_r - 1'b1);
        if (k_r - 1'b1 == start_r) begin
          if (rdata != ST_HEAD) begin
            stat_nxt = STAT_NOTHEAD; st_nxt = S_DONE;
          end else begin
            mctl.wr = 1'b1; taken_nxt = LW'(1);
          end
        end else if (rdata == ST_ALLOC) begin
          mctl.wr = 1'b1; taken_nxt = taken_r + 1'b1;
        end else begin
          st_nxt = S_DONE; stat_nxt = STAT_OK;
          free_nxt = free_r + CntW'(taken_r);
        end
        if (st_nxt == S_REL) begin
          if (k_r == len) begin
            st_nxt = S_DONE; stat_nxt = STAT_OK;
            free_nxt = free_r + CntW'(taken_nxt);
          end else k_nxt = k_r + 1'b1;
        end
      end
      S_DONE: begin
        // Load the output register once the previous word has gone.
        if (!ov_r || out_tready) begin
          ov_nxt = 1'b1; fout_nxt = free_r; res_ff_nxt = ff_r;
          res_st_nxt = stat_r; st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_CLR;
    endcase
    // A register write re-initialises the pool.
    if (cfg_we) begin
      st_nxt = S_CLR; wp_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_CLR; wp_r <= '0; ov_r <= 1'b0;
      base_r <= '0; size_r <= CntW'(1024);
    end else begin
      st_r <= st_nxt; wp_r <= wp_nxt; ov_r <= ov_nxt;
      if (cfg_we && cfg_index == CFG_BASE) base_r <= cfg_wdata;
      if (cfg_we && cfg_index == CFG_SIZE) size_r <= cfg_wdata[CntW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    free_r <= free_nxt; mode_r <= mode_nxt; cnt_r <= cnt_nxt; k_r <= k_nxt;
    run_r <= run_nxt; start_r <= start_nxt; taken_r <= taken_nxt;
    ff_r <= ff_nxt; stat_r <= stat_nxt; fout_r <= fout_nxt;
    res_ff_r <= res_ff_nxt; res_st_r <= res_st_nxt;
  end

  cfa_state_mem #(.MAX_FRAMES(MAX_FRAMES)) u_mem (
    .clk(clk), .waddr(waddr), .ctl(mctl), .raddr(raddr[AW-1:0]), .rdata(rdata)
  );

  assign out_tvalid = ov_r;
  assign out_tdata = {7'd0, fout_r, res_st_r, res_ff_r};

  `CFA_ASSERT_IMP(a_rdy_idle, clk, rst_n, in_tready, st_r == S_IDLE)
  `CFA_ASSERT_NXT(a_acc_busy, clk, rst_n, in_acc && !cfg_we, !in_tready)
  `CFA_ASSERT_IMP(a_ff_zero, clk, rst_n, ov_r && res_st_r != STAT_OK, res_ff_r == '0)
  `CFA_ASSERT_IMP(a_wr_mem, clk, rst_n, st_r == S_WR, mctl.wr)
endmodule

// ----- design/cfa_state_mem.sv -----
// ---------------------------------------------------------------------------
// cfa_state_mem
// Frame state store: one write port, one registered read port.
// ---------------------------------------------------------------------------
module cfa_state_mem
  import cfa_pkg::*;
#(
  parameter int MAX_FRAMES = CfaMaxFrames,
  localparam int AW = $clog2(MAX_FRAMES)
) (
  input  logic          clk,
  input  logic [AW-1:0] waddr,
  input  cfa_mem_ctl_t  ctl,
  input  logic [AW-1:0] raddr,
  output logic [1:0]    rdata
);
  logic [1:0] mem [MAX_FRAMES];

  // Write port.
  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[waddr] <= ctl.wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule

// ----- test/cfa_checker.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// cfa_checker
// Watches the request, result and register channels of the frame allocator.
// It keeps its own copy of the frame state store and free count, works out
// the result of every accepted request and compares each returned word with
// the oldest outstanding prediction, field by field.
// ---------------------------------------------------------------------------
module cfa_checker
  import cfa_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [39:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [19:0] cfg_wdata,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [FnW-1:0]  first_frame;
    logic [1:0]      status;
    logic [CntW-1:0] free_frames;
  } grant_t;

  logic [1:0]      frame_state [CfaMaxFrames];
  logic [FnW-1:0]  pool_base;
  logic [CntW-1:0] pool_size;
  logic [CntW-1:0] free_total;
  grant_t          grant_q[$];

  assign pending = grant_q.size();

  // Frames actually in use: the size clipped to the store, rounded down to four.
  function automatic int pool_len();
    int n;
    n = (pool_size > CfaMaxFrames) ? CfaMaxFrames : int'(pool_size);
    return n & ~3;
  endfunction

  task automatic clear_pool();
    foreach (frame_state[k]) frame_state[k] = ST_FREE;
    free_total = CntW'(pool_len());
  endtask

  task automatic claim_run(input int start, input int n);
    frame_state[start] = ST_HEAD;
    for (int k = 1; k < n; k++) frame_state[start + k] = ST_ALLOC;
  endtask

  // Apply one request to the shadow store and return what the block should say.
  task automatic serve_request(input logic [1:0] md, input logic [FnW-1:0] fn,
                               input logic [CntW-1:0] cnt, output grant_t g);
    int len, run, k, off, freed, taken;
    bit found;
    len = pool_len();
    g.first_frame = '0;
    g.status = STAT_RANGE;
    if (md == MODE_ALLOC) begin
      if (cnt != 0) begin
        g.status = STAT_NOSPACE;
        run = 0;
        found = 0;
        for (k = 0; k < len; k++) begin
          if (frame_state[k] == ST_FREE) begin
            run++;
            if (run == cnt) begin
              found = 1;
              break;
            end
          end else begin
            run = 0;
          end
        end
        if (found) begin
          claim_run(k + 1 - cnt, cnt);
          free_total = free_total - cnt;
          g.first_frame = pool_base + FnW'(k + 1 - cnt);
          g.status = STAT_OK;
        end
      end
    end else if (md == MODE_REL) begin
      if (fn >= pool_base && int'(fn - pool_base) < len) begin
        off = fn - pool_base;
        if (frame_state[off] != ST_HEAD) begin
          g.status = STAT_NOTHEAD;
        end else begin
          freed = 1;
          frame_state[off] = ST_FREE;
          for (k = off + 1; k < len && frame_state[k] == ST_ALLOC; k++) begin
            frame_state[k] = ST_FREE;
            freed++;
          end
          free_total = free_total + CntW'(freed);
          g.status = STAT_OK;
        end
      end
    end else if (md == MODE_MARK) begin
      if (cnt != 0 && fn >= pool_base && int'(fn - pool_base) < len &&
          int'(cnt) <= len - int'(fn - pool_base)) begin
        off = fn - pool_base;
        taken = 0;
        for (k = 0; k < cnt; k++)
          if (frame_state[off + k] == ST_FREE) taken++;
        claim_run(off, cnt);
        free_total = free_total - CntW'(taken);
        g.status = STAT_OK;
      end
    end
    g.free_frames = free_total;
  endtask

  // Requests are applied before results are popped, so a word accepted on the
  // same edge as a result always lands behind it in the queue.
  always @(posedge clk) begin
    grant_t g, got, want;
    if (!rst_n) begin
      pool_base = '0;
      pool_size = CntW'(1024);
      clear_pool();
      grant_q.delete();
      fail_count = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_BASE) pool_base = cfg_wdata;
        else pool_size = cfg_wdata[CntW-1:0];
        clear_pool();
      end
      if (in_tvalid && in_tready) begin
        serve_request(in_tdata[1:0], in_tdata[21:2], in_tdata[32:22], g);
        grant_q.push_back(g);
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[19:0], out_tdata[21:20], out_tdata[32:22]};
        if (grant_q.size() == 0) begin
          $error("unexpected result word %h", out_tdata);
          fail_count++;
        end else begin
          want = grant_q.pop_front();
          if (got.first_frame !== want.first_frame) begin
            $error("first_frame: expected %h, got %h", want.first_frame, got.first_frame);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fail_count++;
          end
          if (got.free_frames !== want.free_frames) begin
            $error("free_frames: expected %0d, got %0d", want.free_frames,
                   got.free_frames);
            fail_count++;
          end
        end
      end
    end
  end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// Stimulus for the contiguous frame allocator: a directed pass over the
// corner cases, then random phases under several pool settings with random
// idling on both channels. The checker beside the block gives the verdict.
// ---------------------------------------------------------------------------
module tb_top;
  import cfa_pkg::*;

  localparam int SettleCycles = 2200;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;   // mode, frame_number, frame_count
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;       // first_frame, status, free_frames
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [19:0] cfg_wdata = '0;
  int          fail_count;
  int          pending;
  bit          calm = 1'b0;

  // Current pool setting and the heads handed out, used to aim releases.
  logic [19:0] cur_base = '0;
  int          cur_len = 1024;
  logic [19:0] head_q[$];

  always #5 clk = ~clk;

  contiguous_frame_allocator dut (.*);

  cfa_checker u_checker (.*);

  // The result side stalls at random unless the quiet stretch is on.
  always @(posedge clk)
    out_tready <= calm || ($urandom_range(99) >= 16);

  // Remember successful allocations so that releases hit real heads.
  always @(posedge clk)
    if (out_tvalid && out_tready && out_tdata[21:20] == STAT_OK && out_tdata[19:0] != 0)
      head_q.push_back(out_tdata[19:0]);

  task automatic send_word(input logic [1:0] md, input logic [19:0] fn,
                           input logic [10:0] cnt);
    in_tvalid <= 1'b1;
    in_tdata <= {7'd0, cnt, fn, md};
    do @(posedge clk); while (!in_tready);
    if (!calm && $urandom_range(99) < 16) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Registers change only once the block has gone quiet.
  task automatic write_reg(input logic idx, input logic [19:0] val);
    drain();
    repeat (SettleCycles) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    head_q.delete();
  endtask

  task automatic set_pool(input logic [19:0] base, input int size);
    write_reg(CFG_BASE, base);
    write_reg(CFG_SIZE, 20'(size));
    cur_base = base;
    cur_len = ((size > 1024) ? 1024 : size) & ~3;
  endtask

  // Mostly well-formed traffic in the pool, with some noise over whole fields.
  task automatic random_phase(input int n);
    int pick, off, idx;
    logic [19:0] fn;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(99);
      off = $urandom_range(cur_len - 1);
      if (pick < 45) begin
        send_word(MODE_ALLOC, 20'($urandom), 11'($urandom_range(cur_len / 4 + 1, 1)));
      end else if (pick < 75) begin
        if (head_q.size() != 0 && $urandom_range(3) != 0) begin
          idx = $urandom_range(head_q.size() - 1);
          fn = head_q[idx];
          head_q.delete(idx);
        end else begin
          fn = cur_base + 20'(off);
        end
        send_word(MODE_REL, fn, 11'($urandom));
      end else if (pick < 88) begin
        send_word(MODE_MARK, cur_base + 20'(off),
                  11'($urandom_range(cur_len / 4 + 2, 0)));
      end else begin
        send_word(2'($urandom), 20'($urandom), 11'($urandom));
      end
    end
  endtask

  initial begin
    #50ms;
    $display("FAILURE");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pass over the default pool of 1024 frames at base zero.
    send_word(MODE_ALLOC, '0, 11'd0);         // zero count
    send_word(MODE_ALLOC, '0, 11'd1);
    send_word(MODE_ALLOC, '0, 11'd1024);      // no run left
    send_word(MODE_REL, 20'd0, '0);
    send_word(MODE_ALLOC, '0, 11'd1024);      // whole pool
    send_word(MODE_REL, 20'd0, '0);           // walk to the end of the pool
    send_word(MODE_MARK, 20'd5, 11'd3);
    send_word(MODE_MARK, 20'd6, 11'd4);       // overwrites used frames
    send_word(MODE_REL, 20'd7, '0);           // not a head
    send_word(MODE_REL, 20'd6, '0);
    send_word(MODE_REL, 20'd5, '0);           // walk stops at a free frame
    send_word(MODE_REL, 20'd1024, '0);        // past the pool
    send_word(MODE_REL, 20'hFFFFF, '0);
    send_word(MODE_MARK, 20'd1022, 11'd3);    // runs off the end
    send_word(MODE_MARK, 20'd1020, 11'd4);
    send_word(MODE_MARK, 20'd3, 11'd0);       // zero count
    send_word(2'd3, 20'hFFFFF, 11'h7FF);      // unused mode
    send_word(MODE_ALLOC, '0, 11'h7FF);
    send_word(MODE_REL, 20'd1020, '0);
    drain();
    calm = 1'b1;
    random_phase(40);
    calm = 1'b0;

    set_pool(20'hFFFF0, 200);                 // first frame wraps around
    random_phase(140);
    drain();                                  // sender waits for every result
    random_phase(20);
    set_pool(20'hFFFFC, 4);
    random_phase(60);
    set_pool(20'h12345, 37);
    send_word(MODE_REL, 20'h12344, '0);       // just below the base
    random_phase(100);
    set_pool(20'd0, 1024);
    random_phase(60);
    set_pool(20'hABCDE, 64);
    random_phase(130);

    drain();
    repeat (SettleCycles) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ----- contiguous_frame_allocator.f -----
+incdir+design
design/cfa_pkg.sv
design/cfa_state_mem.sv
design/contiguous_frame_allocator.sv
test/cfa_checker.sv
test/tb_top.sv
